// ===== sv/ps2mt_pkg.sv =====
// Shared constants for the PS/2 mouse packet cursor tracker.
`default_nettype none

package ps2mt_pkg;

  // Field widths of the channels.
  localparam int BYTE_W      = 8;
  localparam int FIELD_POS_W = 16;
  localparam int MOVE_W      = 17;
  localparam int BTN_W       = 3;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  // Width of a signed motion value: nine-bit packet value plus overflow extension.
  localparam int MOTION_W = 10;

  // Header byte bit positions.
  localparam int HDR_SYNC_BIT  = 3;
  localparam int HDR_XSIGN_BIT = 4;
  localparam int HDR_YSIGN_BIT = 5;
  localparam int HDR_XOVF_BIT  = 6;
  localparam int HDR_YOVF_BIT  = 7;

  // Extra magnitude added when a motion overflow bit is set.
  localparam logic signed [MOTION_W-1:0] OVF_EXTRA = 10'sd255;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 8'd1;

  // Register values after reset.
  localparam logic [CFG_DATA_W-1:0] SCREEN_WIDTH_RST  = 16'd1024;
  localparam logic [CFG_DATA_W-1:0] SCREEN_HEIGHT_RST = 16'd768;

endpackage

`default_nettype wire

// ===== sv/ps2mt_if.sv =====
// Handshake interfaces for the byte input, result output and configuration channels.
`default_nettype none

interface ps2mt_in_if;
  import ps2mt_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ps2mt_res_if;
  import ps2mt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [FIELD_POS_W-1:0]   cursor_x;
  logic [FIELD_POS_W-1:0]   cursor_y;
  logic signed [MOVE_W-1:0] move_x;
  logic signed [MOVE_W-1:0] move_y;
  logic                     moved;
  logic [BTN_W-1:0]         button_state;
  logic [BTN_W-1:0]         button_toggled;

  modport source (output valid, output cursor_x, output cursor_y, output move_x,
                  output move_y, output moved, output button_state,
                  output button_toggled, input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, input move_x,
                  input move_y, input moved, input button_state,
                  input button_toggled, output ready);
endinterface

interface ps2mt_cfg_if;
  import ps2mt_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/ps2_mouse_packet_cursor_tracker.sv =====
// Top level: PS/2 mouse packet framer and clamped cursor tracker.
//
//  Channel | Direction | Payload                                    | Transfer
//  --------+-----------+--------------------------------------------+-------------------
//  rx      | in        | rx_byte                                    | rx.valid & rx.ready
//  res     | out       | cursor_x/y, move_x/y, moved, buttons       | res.valid & res.ready
//  cfg     | in        | index, data (screen_width, screen_height)  | cfg.valid & cfg.ready
//
// One byte is taken every cycle but for the stall below. Each byte is held in the input
// register; when a packet's third byte leaves it, the result is written to the result
// register through a single combinational pass (sign extension, add, clamp compare).
// Reset is synchronous; the first byte after reset is discarded, as the mouse
// acknowledge is. A stalled result holds the result register, and input bytes stall
// only when the byte in the input register completes a packet that cannot yet be stored.
`default_nettype none

module ps2_mouse_packet_cursor_tracker #(
  parameter int POSITION_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  ps2mt_cfg_if.sink   cfg,
  ps2mt_in_if.sink    rx,
  ps2mt_res_if.source res
);
  import ps2mt_pkg::*;

  // Working width for signed position arithmetic, always wider than the output fields.
  localparam int PW = POSITION_WIDTH;
  localparam int SW = ((PW > FIELD_POS_W) ? PW : FIELD_POS_W) + 2;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_X      = 2'd1,
    PH_Y      = 2'd2
  } phase_t;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] screen_width;
  logic [CFG_DATA_W-1:0] screen_height;

  // Framing and tracking state.
  logic              skip_pending;
  phase_t            byte_phase;
  phase_t            byte_phase_next;
  logic [BYTE_W-1:0] header_byte;
  logic [BYTE_W-1:0] x_byte;
  logic [PW-1:0]     pos_x;
  logic [PW-1:0]     pos_y;
  logic [BTN_W-1:0]  last_buttons;

  // Input register.
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;

  // Result register.
  logic                     out_valid;
  logic [FIELD_POS_W-1:0]   out_cursor_x;
  logic [FIELD_POS_W-1:0]   out_cursor_y;
  logic signed [MOVE_W-1:0] out_move_x;
  logic signed [MOVE_W-1:0] out_move_y;
  logic                     out_moved;
  logic [BTN_W-1:0]         out_buttons;
  logic [BTN_W-1:0]         out_toggled;

  // Datapath signals.
  logic                       produce;
  logic                       advance;
  logic signed [MOTION_W-1:0] dx;
  logic signed [MOTION_W-1:0] dy;
  logic [SW-1:0]              pos_max_ext;
  logic [SW-1:0]              limit_x;
  logic [SW-1:0]              limit_y;
  logic [SW-1:0]              hi_x;
  logic [SW-1:0]              hi_y;
  logic [SW-1:0]              pos_x_ext;
  logic [SW-1:0]              pos_y_ext;
  logic [SW-1:0]              sum_x;
  logic [SW-1:0]              sum_y;
  logic [SW-1:0]              nx;
  logic [SW-1:0]              ny;
  logic [SW-1:0]              mx;
  logic [SW-1:0]              my;
  logic [BTN_W-1:0]           btn;

  // Signed motion from a data byte, its sign bit and its overflow bit.
  function automatic logic signed [MOTION_W-1:0] motion(
    input logic [BYTE_W-1:0] data,
    input logic              neg,
    input logic              ovf
  );
    logic signed [MOTION_W-1:0] m;
    m = signed'({neg, neg, data});
    if (ovf) begin
      m = neg ? (m - OVF_EXTRA) : (m + OVF_EXTRA);
    end
    return m;
  endfunction

  // Pipeline flow: the input register moves on unless it holds a packet end that
  // finds the result register full and not being drained.
  assign produce  = in_valid && !skip_pending && (byte_phase == PH_Y);
  assign advance  = in_valid && (!out_valid || res.ready || !produce);
  assign rx.ready = !in_valid || advance;
  assign cfg.ready = 1'b1;

  // Motion of this packet; the Y byte is the one in the input register.
  assign dx = motion(x_byte, header_byte[HDR_XSIGN_BIT], header_byte[HDR_XOVF_BIT]);
  assign dy = motion(in_byte, header_byte[HDR_YSIGN_BIT], header_byte[HDR_YOVF_BIT]);
  assign btn = header_byte[BTN_W-1:0];

  // Upper clamp limits: size minus one where the size is nonzero, never above the
  // saturation value of the position register.
  assign pos_max_ext = {{(SW-PW){1'b0}}, {PW{1'b1}}};
  assign limit_x = {{(SW-CFG_DATA_W){1'b0}}, screen_width - 16'd1};
  assign limit_y = {{(SW-CFG_DATA_W){1'b0}}, screen_height - 16'd1};
  assign hi_x = ((screen_width != '0) && (limit_x < pos_max_ext)) ? limit_x : pos_max_ext;
  assign hi_y = ((screen_height != '0) && (limit_y < pos_max_ext)) ? limit_y : pos_max_ext;

  // New positions before clamping; screen Y grows downward, so Y motion is subtracted.
  assign pos_x_ext = {{(SW-PW){1'b0}}, pos_x};
  assign pos_y_ext = {{(SW-PW){1'b0}}, pos_y};
  assign sum_x = pos_x_ext + {{(SW-MOTION_W){dx[MOTION_W-1]}}, dx};
  assign sum_y = pos_y_ext - {{(SW-MOTION_W){dy[MOTION_W-1]}}, dy};

  // Clamp to zero below and to the limit above.
  always_comb begin
    if (sum_x[SW-1]) begin
      nx = '0;
    end else if (sum_x > hi_x) begin
      nx = hi_x;
    end else begin
      nx = sum_x;
    end
    if (sum_y[SW-1]) begin
      ny = '0;
    end else if (sum_y > hi_y) begin
      ny = hi_y;
    end else begin
      ny = sum_y;
    end
  end

  assign mx = nx - pos_x_ext;
  assign my = ny - pos_y_ext;

  // Next framing phase for the byte in the input register.
  always_comb begin
    byte_phase_next = byte_phase;
    unique case (byte_phase)
      PH_X: begin
        byte_phase_next = PH_Y;
      end
      PH_Y: begin
        byte_phase_next = PH_HEADER;
      end
      default: begin
        if (in_byte[HDR_SYNC_BIT]) begin
          byte_phase_next = PH_X;
        end
      end
    endcase
  end

  // Configuration writes; indexes beyond the register list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg.data;
        REG_SCREEN_HEIGHT: screen_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
    if (rx.ready && rx.valid) begin
      in_byte <= rx.rx_byte;
    end
  end

  // Framing state, cursor state and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_pending <= 1'b1;
      byte_phase   <= PH_HEADER;
      header_byte  <= '0;
      x_byte       <= '0;
      pos_x        <= '0;
      pos_y        <= '0;
      last_buttons <= '0;
      out_valid    <= 1'b0;
    end else begin
      // A new result fills the register; otherwise a transfer empties it.
      if (advance && produce) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        if (skip_pending) begin
          skip_pending <= 1'b0;
        end else begin
          byte_phase <= byte_phase_next;
          if (byte_phase == PH_X) begin
            x_byte <= in_byte;
          end else if (byte_phase != PH_Y && in_byte[HDR_SYNC_BIT]) begin
            header_byte <= in_byte;
          end
          if (produce) begin
            pos_x        <= nx[PW-1:0];
            pos_y        <= ny[PW-1:0];
            last_buttons <= btn;
            out_cursor_x <= nx[FIELD_POS_W-1:0];
            out_cursor_y <= ny[FIELD_POS_W-1:0];
            out_move_x   <= signed'(mx[MOVE_W-1:0]);
            out_move_y   <= signed'(my[MOVE_W-1:0]);
            out_moved    <= (mx != '0) || (my != '0);
            out_buttons  <= btn;
            out_toggled  <= btn ^ last_buttons;
          end
        end
      end
    end
  end

  assign res.valid          = out_valid;
  assign res.cursor_x       = out_cursor_x;
  assign res.cursor_y       = out_cursor_y;
  assign res.move_x         = out_move_x;
  assign res.move_y         = out_move_y;
  assign res.moved          = out_moved;
  assign res.button_state   = out_buttons;
  assign res.button_toggled = out_toggled;

endmodule

`default_nettype wire

// ===== sv/ps2mt_checker.sv =====
// Port-level checker for the PS/2 mouse cursor tracker, with its bind statement.
`default_nettype none

module ps2mt_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 res_valid,
  input logic                                 res_ready,
  input logic [ps2mt_pkg::FIELD_POS_W-1:0]    res_cursor_x,
  input logic [ps2mt_pkg::FIELD_POS_W-1:0]    res_cursor_y,
  input logic signed [ps2mt_pkg::MOVE_W-1:0]  res_move_x,
  input logic signed [ps2mt_pkg::MOVE_W-1:0]  res_move_y,
  input logic                                 res_moved
);
  import ps2mt_pkg::*;

  // A stalled result keeps its position fields.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_cursor_x) && $stable(res_cursor_y))
    else $error("result changed while stalled");

  // The moved flag agrees with the two reported changes.
  a_moved: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_moved == ((res_move_x != '0) || (res_move_y != '0))))
    else $error("moved flag disagrees with the changes");

  // No result straight after reset.
  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result present after reset");

  // A stalled result also keeps its change fields and moved flag.
  a_res_hold_move: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=>
      $stable(res_move_x) && $stable(res_move_y) && $stable(res_moved))
    else $error("change fields altered while stalled");

endmodule

bind ps2_mouse_packet_cursor_tracker ps2mt_checker u_ps2mt_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_cursor_x (res.cursor_x),
  .res_cursor_y (res.cursor_y),
  .res_move_x   (res.move_x),
  .res_move_y   (res.move_y),
  .res_moved    (res.moved)
);

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the PS/2 mouse packet cursor tracker.
`timescale 1ns / 1ps

module testbench;
  import ps2mt_pkg::*;

  localparam int POSITION_WIDTH = 16;
  localparam int POS_MAX        = (1 << POSITION_WIDTH) - 1;
  localparam int NEG_SPAN       = 256;
  localparam int IDLE_LIMIT     = 1000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int MAX_PRINTED    = 40;

  // Indexes that map to no register; writes to them must be ignored.
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LOW = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_TOP = 8'hFF;

  typedef enum logic [1:0] {PH_HEADER, PH_X, PH_Y} frame_phase_t;
  typedef enum int {DRIFT_NONE, DRIFT_UP, DRIFT_DOWN} drift_t;

  typedef struct packed {
    logic [FIELD_POS_W-1:0]   cursor_x;
    logic [FIELD_POS_W-1:0]   cursor_y;
    logic signed [MOVE_W-1:0] move_x;
    logic signed [MOVE_W-1:0] move_y;
    logic                     moved;
    logic [BTN_W-1:0]         button_state;
    logic [BTN_W-1:0]         button_toggled;
  } cursor_report_t;

  logic clk = 1'b0;
  logic rst;

  ps2mt_cfg_if cfg_bus ();
  ps2mt_in_if  rx_bus ();
  ps2mt_res_if res_bus ();

  ps2_mouse_packet_cursor_tracker #(.POSITION_WIDTH(POSITION_WIDTH)) uut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_bus),
    .rx  (rx_bus),
    .res (res_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bytes waiting to be sent and cursor reports waiting to arrive.
  logic [BYTE_W-1:0] mouse_bytes[$];
  cursor_report_t    expected_reports[$];

  int errors       = 0;
  int bytes_sent   = 0;
  int reports_seen = 0;
  int reg_writes   = 0;
  int idle_cycles  = 0;

  // Predictor state, mirroring the block after reset.
  bit                   drop_next   = 1'b1;
  frame_phase_t         frame_phase = PH_HEADER;
  logic [BYTE_W-1:0]    hdr_data    = '0;
  logic [BYTE_W-1:0]    x_data      = '0;
  int                   cur_x       = 0;
  int                   cur_y       = 0;
  logic [BTN_W-1:0]     prev_buttons = '0;
  logic [CFG_DATA_W-1:0] limit_w    = SCREEN_WIDTH_RST;
  logic [CFG_DATA_W-1:0] limit_h    = SCREEN_HEIGHT_RST;

  // Signed motion from a data byte and the sign and overflow bits of the header.
  function automatic int motion_of(logic [BYTE_W-1:0] data, logic neg, logic ovf);
    int m;
    if (neg) begin
      m = -(NEG_SPAN - int'(data));
      if (ovf) m = m - int'(OVF_EXTRA);
    end else begin
      m = int'(data);
      if (ovf) m = m + int'(OVF_EXTRA);
    end
    return m;
  endfunction

  // Clamp one axis to zero and to the screen size, or to the position range.
  function automatic int clamp_axis(int v, logic [CFG_DATA_W-1:0] size);
    int hi;
    hi = POS_MAX;
    if (size != 0 && int'(size) - 1 < hi) hi = int'(size) - 1;
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the packet framer by one byte; a completed packet yields a report.
  task automatic apply_mouse_byte(input logic [BYTE_W-1:0] b, output bit emit,
                                  output cursor_report_t rep);
    int dx, dy, nx, ny;
    logic [BTN_W-1:0] btn;
    emit = 1'b0;
    rep  = '0;
    if (drop_next) begin
      drop_next = 1'b0;
    end else begin
      case (frame_phase)
        PH_X: begin
          x_data      = b;
          frame_phase = PH_Y;
        end
        PH_Y: begin
          frame_phase = PH_HEADER;
          dx  = motion_of(x_data, hdr_data[HDR_XSIGN_BIT], hdr_data[HDR_XOVF_BIT]);
          dy  = motion_of(b, hdr_data[HDR_YSIGN_BIT], hdr_data[HDR_YOVF_BIT]);
          nx  = clamp_axis(cur_x + dx, limit_w);
          ny  = clamp_axis(cur_y - dy, limit_h);
          btn = hdr_data[BTN_W-1:0];
          rep.cursor_x       = nx[FIELD_POS_W-1:0];
          rep.cursor_y       = ny[FIELD_POS_W-1:0];
          rep.move_x         = MOVE_W'(nx - cur_x);
          rep.move_y         = MOVE_W'(ny - cur_y);
          rep.moved          = (nx != cur_x) || (ny != cur_y);
          rep.button_state   = btn;
          rep.button_toggled = btn ^ prev_buttons;
          cur_x        = nx;
          cur_y        = ny;
          prev_buttons = btn;
          emit         = 1'b1;
        end
        default: begin
          // Waiting for a header: only a byte with the sync bit starts a packet.
          if (b[HDR_SYNC_BIT]) begin
            hdr_data    = b;
            frame_phase = PH_X;
          end
        end
      endcase
    end
  endtask

  task automatic report_mismatch(input string what);
    if (errors < MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  task automatic check_report(input cursor_report_t want);
    if (res_bus.cursor_x !== want.cursor_x)
      report_mismatch($sformatf("cursor_x got %0d expected %0d",
                                res_bus.cursor_x, want.cursor_x));
    if (res_bus.cursor_y !== want.cursor_y)
      report_mismatch($sformatf("cursor_y got %0d expected %0d",
                                res_bus.cursor_y, want.cursor_y));
    if (res_bus.move_x !== want.move_x)
      report_mismatch($sformatf("move_x got %0d expected %0d",
                                res_bus.move_x, want.move_x));
    if (res_bus.move_y !== want.move_y)
      report_mismatch($sformatf("move_y got %0d expected %0d",
                                res_bus.move_y, want.move_y));
    if (res_bus.moved !== want.moved)
      report_mismatch($sformatf("moved got %0b expected %0b", res_bus.moved, want.moved));
    if (res_bus.button_state !== want.button_state)
      report_mismatch($sformatf("button_state got %0h expected %0h",
                                res_bus.button_state, want.button_state));
    if (res_bus.button_toggled !== want.button_toggled)
      report_mismatch($sformatf("button_toggled got %0h expected %0h",
                                res_bus.button_toggled, want.button_toggled));
  endtask

  // Set when the byte on the input channel has been transferred.
  bit rx_taken = 1'b0;

  // Monitor: follows every transfer, runs the predictor and checks reports.
  always @(posedge clk) begin
    bit             emit;
    bit             progress;
    cursor_report_t rep;
    if (!rst) begin
      progress = 1'b0;
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          REG_SCREEN_WIDTH:  limit_w = cfg_bus.data;
          REG_SCREEN_HEIGHT: limit_h = cfg_bus.data;
          default: ;
        endcase
        reg_writes++;
        progress = 1'b1;
      end
      if (rx_bus.valid && rx_bus.ready) begin
        apply_mouse_byte(rx_bus.rx_byte, emit, rep);
        if (emit) expected_reports.push_back(rep);
        void'(mouse_bytes.pop_front());
        rx_taken = 1'b1;
        bytes_sent++;
        progress = 1'b1;
      end
      if (res_bus.valid && res_bus.ready) begin
        if (expected_reports.size() == 0) begin
          report_mismatch($sformatf("report at (%0d,%0d) with none expected",
                                    res_bus.cursor_x, res_bus.cursor_y));
        end else begin
          check_report(expected_reports.pop_front());
        end
        reports_seen++;
        progress = 1'b1;
      end
      // Watchdog on cycles without any transfer.
      if (progress) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("watchdog: no transfer for %0d cycles, %0d reports outstanding",
                   IDLE_LIMIT, expected_reports.size());
          $display("testbench: FAIL");
          $finish;
        end
      end
    end
  end

  // Byte sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (rst) begin
      rx_bus.valid   <= 1'b0;
      rx_bus.rx_byte <= '0;
    end else if (!(rx_bus.valid && !rx_taken)) begin
      rx_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        rx_bus.valid <= 1'b0;
      end else if (mouse_bytes.size() > 0) begin
        rx_bus.valid   <= 1'b1;
        rx_bus.rx_byte <= mouse_bytes[0];
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                   : $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        rx_bus.valid <= 1'b0;
      end
    end
  end

  // Report receiver: stalls following a random 16-bit ready pattern that is replayed and then redrawn.
  logic [15:0] stall_pattern = '1;
  int          stall_step    = 0;

  always @(negedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (stall_step == 0)
        stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                    : (16'($urandom) | 16'h0001);
      res_bus.ready <= stall_pattern[stall_step % 16];
      stall_step = (stall_step + 1) % 48;
    end
  end

  // Register write; valid is left high so back-to-back writes need no gap.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  task automatic set_screen(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Hold off until every byte is transferred and every report has arrived.
  task automatic wait_drained();
    while (mouse_bytes.size() != 0 || expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Queue well-formed packets with random content, with some stray bytes mixed in.
  task automatic queue_packets(input int count, input drift_t drift);
    int                added;
    logic [BYTE_W-1:0] hdr, xb, yb;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 11) == 0) begin
        mouse_bytes.push_back(8'($urandom));
      end else begin
        hdr = 8'($urandom);
        xb  = 8'($urandom);
        yb  = 8'($urandom);
        hdr[HDR_SYNC_BIT] = 1'b1;
        if (drift != DRIFT_NONE) begin
          // Large moves towards the far corner (up) or the origin (down).
          hdr[HDR_XSIGN_BIT] = (drift == DRIFT_DOWN);
          hdr[HDR_YSIGN_BIT] = (drift == DRIFT_UP);
          hdr[HDR_XOVF_BIT]  = 1'b1;
          hdr[HDR_YOVF_BIT]  = 1'b1;
          xb[BYTE_W-1]       = (drift == DRIFT_UP);
          yb[BYTE_W-1]       = (drift == DRIFT_DOWN);
        end
        mouse_bytes.push_back(hdr);
        mouse_bytes.push_back(xb);
        mouse_bytes.push_back(yb);
        added += 3;
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = '0;
    cfg_bus.data   = '0;
    rx_bus.valid   = 1'b0;
    rx_bus.rx_byte = '0;
    res_bus.ready  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset screen size: acknowledge byte dropped, a byte
    // without the sync bit ignored, a zero packet, full overflow moves in both
    // directions, a negative zero byte, every button, and the right-hand edge.
    mouse_bytes = '{8'hFA, 8'hF7,
                    8'h08, 8'h00, 8'h00,
                    8'h4F, 8'hFF, 8'h00,
                    8'h98, 8'h00, 8'hFF,
                    8'h7B, 8'h01, 8'h00,
                    8'hEC, 8'h80, 8'h80,
                    8'h48, 8'hFF, 8'h00,
                    8'h48, 8'hFF, 8'h00,
                    8'hC8, 8'hFF, 8'hFF};
    queue_packets(350, DRIFT_NONE);
    wait_drained();

    // No screen limit: drive the cursor into saturation at the top of the range.
    set_screen(16'd0, 16'd0);
    queue_packets(600, DRIFT_UP);
    wait_drained();

    // Largest screen size, so the saturated cursor is pulled back by one.
    set_screen(16'hFFFF, 16'hFFFF);
    queue_packets(150, DRIFT_NONE);
    wait_drained();

    // One-pixel screen; writes to unmapped indexes must change nothing.
    set_screen(16'd1, 16'd1);
    write_reg(REG_UNMAPPED_LOW, 16'd5);
    write_reg(REG_UNMAPPED_TOP, 16'hFFFF);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    queue_packets(150, DRIFT_NONE);
    wait_drained();

    // Small screen, so the clamps act on most packets.
    set_screen(16'd16, 16'd9);
    queue_packets(250, DRIFT_NONE);
    wait_drained();

    // Ordinary screen: back to the origin, then random wander.
    set_screen(16'd640, 16'd480);
    queue_packets(100, DRIFT_DOWN);
    queue_packets(250, DRIFT_NONE);
    wait_drained();

    $display("run covered %0d mouse bytes and %0d cursor reports", bytes_sent, reports_seen);
    $display("over six screen settings with %0d register writes", reg_writes);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== ps2_mouse_packet_cursor_tracker.f =====
sv/ps2mt_pkg.sv
sv/ps2mt_if.sv
sv/ps2_mouse_packet_cursor_tracker.sv
sv/ps2mt_checker.sv
sim/testbench.sv
